// File: src/mts_pkg.sv
// Shared types, constants and helpers for the markup tag scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

	localparam int MAX_TAGS    = 4096;
	localparam int MAX_TEXT    = 65536;
	localparam int LEVEL_RANGE = 64;

	localparam int LVL_W   = $clog2(LEVEL_RANGE);
	localparam int IDX_W   = 12;
	localparam int POS_W   = $clog2(MAX_TEXT);
	localparam int CNT_W   = 13;
	localparam int DEPTH_W = 8;

	localparam logic signed [LVL_W-1:0] LVL_MIN = 6'sh20;  // -32
	localparam logic signed [LVL_W-1:0] LVL_MAX = 6'sh1F;  // +31

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// delimiter bytes
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic             en;
		logic [LVL_W-1:0] idx;
		logic [IDX_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic                    last_result;
		logic                    done_res;
		logic [CNT_W-1:0]        tag_count;
		logic                    level_clipped;
		logic                    parent_found;
		logic [IDX_W-1:0]        parent;
		logic signed [LVL_W-1:0] level;
		logic [POS_W-1:0]        tag_len;
		logic [POS_W-1:0]        tag_pos;
		logic [IDX_W-1:0]        tag_index;
	} result_t;

	// signed level -> table row (offset by half the range)
	function automatic logic [LVL_W-1:0] lvl_to_idx(input logic signed [LVL_W-1:0] lvl);
		lvl_to_idx = {~lvl[LVL_W-1], lvl[LVL_W-2:0]};
	endfunction

endpackage

`default_nettype wire

// File: src/mts_level_table.sv
// Per-level table of the latest tag index, with valid bits and registered read.
// Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_level_table
	import mts_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tbl_wr_t          wr,
	input  wire logic             clr,       // drop all entries
	input  wire logic [LVL_W-1:0] rd_idx,    // row to prefetch for next cycle
	output logic      [IDX_W-1:0] rd_data,   // registered read of rd_idx
	input  wire logic [LVL_W-1:0] vld_idx,
	output logic                  vld
);

	logic [IDX_W-1:0]       mem [LEVEL_RANGE];
	logic [IDX_W-1:0]       rd_q;
	logic [LEVEL_RANGE-1:0] valid_q;

	// write-first: a write to the prefetched row is forwarded
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (wr.en && wr.idx == rd_idx) begin
			rd_q <= wr.data;
		end else begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	assign rd_data = rd_q;
	assign vld     = valid_q[vld_idx];

endmodule

`default_nettype wire

// File: src/mts_result_fifo.sv
// Small result queue: takes up to two results a cycle, gives one while out_ready is high.
// Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_result_fifo
	import mts_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic [1:0] push_n,  // 0, 1 or 2 results
	input  wire result_t d0,
	input  wire result_t d1,
	output logic         room,       // space for two more
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic                   pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: src/markup_tag_scanner_with_nesting_top.sv
// Markup tag scanner, top level: input register, scan logic, level table, result queue.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a tag
// and ends the text makes two words, which drain through a four-word result queue, one per
// cycle while m_axis_tready is high.
// Reset: arst_n clears all scan state, the table valid bits and the queue; no clearing pass.
// Depends on mts_pkg, mts_level_table, mts_result_fifo.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_scanner_with_nesting_top
	import mts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side: one text byte per word
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // last byte of the text
	// master side: one result per word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,   // [11:0] tag_index, [27:12] tag_pos,
	                                         // [43:28] tag_len, [49:44] level,
	                                         // [61:50] parent, [62] parent_found,
	                                         // [63] level_clipped, [76:64] tag_count, rest 0
	output logic             m_axis_tuser,   // done_res
	output logic             m_axis_tlast    // last_result
);

	// ---------------------------------------------------------------
	// Input register stage
	// ---------------------------------------------------------------
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       room;
	logic       proc;      // the byte in s1 is consumed this cycle

	assign proc          = v_s1 && room;
	assign s_axis_tready = !v_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------
	// Scan state
	// ---------------------------------------------------------------
	logic                    inside_q, inside_d;
	logic [DEPTH_W-1:0]      cd_q, cd_d;          // comment depth
	logic [7:0]              prev_q;
	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        start_q, start_d;
	logic                    closing_q, closing_d;
	logic                    sbp_q, sbp_d;        // waiting on the byte after '<'
	logic [CNT_W-1:0]        tags_q, tags_d;
	logic signed [LVL_W-1:0] level_q, level_d;

	// level table hookup
	tbl_wr_t          tbl_wr;
	logic [IDX_W-1:0] tbl_rd_data;
	logic             tbl_vld;
	logic [LVL_W-1:0] par_idx;

	// per-byte decode
	logic                    closing;    // closing mark as seen by this byte
	logic [DEPTH_W-1:0]      cd_dec;
	logic                    emit;
	logic                    prev_cut;   // '/' or '-' just before '>'
	logic signed [7:0]       lvl_ext;
	logic signed [7:0]       nxt_raw;
	logic signed [LVL_W-1:0] nxt_sat;
	logic                    clip;
	logic                    par_ok;
	result_t                 tag_res;
	result_t                 done_res;
	result_t                 res0;
	logic [1:0]              push_n;
	logic                    fin;

	assign fin      = last_s1;
	assign closing  = sbp_q ? (ch_s1 == CH_SLASH) : closing_q;
	assign cd_dec   = (prev_q == CH_DASH) ? cd_q - DEPTH_W'(1) : cd_q;
	assign prev_cut = (prev_q == CH_SLASH) || (prev_q == CH_DASH);

	// next level: +1, -2 for a closing tag, -1 for a self-closed tag, then clamp
	assign lvl_ext = {{(8 - LVL_W){level_q[LVL_W-1]}}, level_q};
	assign nxt_raw = lvl_ext + 8'sd1 - (closing ? 8'sd2 : 8'sd0) - (prev_cut ? 8'sd1 : 8'sd0);

	// bounds are sign-extended so the compare stays signed
	always_comb begin
		clip    = 1'b0;
		nxt_sat = nxt_raw[LVL_W-1:0];
		if (nxt_raw > $signed({{(8 - LVL_W){1'b0}}, LVL_MAX})) begin
			nxt_sat = LVL_MAX;
			clip    = 1'b1;
		end else if (nxt_raw < $signed({{(8 - LVL_W){1'b1}}, LVL_MIN})) begin
			nxt_sat = LVL_MIN;
			clip    = 1'b1;
		end
	end

	always_comb begin
		inside_d  = inside_q;
		cd_d      = cd_q;
		start_d   = start_q;
		closing_d = closing;
		sbp_d     = 1'b0;
		tags_d    = tags_q;
		level_d   = level_q;
		emit      = 1'b0;
		case (ch_s1)
			CH_LT: begin
				if (cd_q == '0) begin
					start_d   = pos_q;
					inside_d  = 1'b1;
					sbp_d     = 1'b1;
					closing_d = 1'b0;
				end
			end
			CH_BANG: begin
				if (inside_q && prev_q == CH_LT && cd_q != '1) begin
					cd_d = cd_q + DEPTH_W'(1);
				end
			end
			CH_GT: begin
				if (cd_q != '0) begin
					// '->' closes one comment level; the tag goes when none is left
					cd_d = cd_dec;
					if (cd_dec == '0) begin
						inside_d = 1'b0;
					end
				end else if (inside_q) begin
					inside_d = 1'b0;
					if (tags_q < CNT_W'(MAX_TAGS)) begin
						emit    = 1'b1;
						level_d = nxt_sat;
						tags_d  = tags_q + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		// end of text: back to the reset state
		if (fin) begin
			inside_d  = 1'b0;
			cd_d      = '0;
			start_d   = '0;
			closing_d = 1'b0;
			sbp_d     = 1'b0;
			tags_d    = '0;
			level_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			cd_q      <= '0;
			prev_q    <= '0;
			pos_q     <= '0;
			start_q   <= '0;
			closing_q <= 1'b0;
			sbp_q     <= 1'b0;
			tags_q    <= '0;
			level_q   <= '0;
		end else if (proc) begin
			inside_q  <= inside_d;
			cd_q      <= cd_d;
			prev_q    <= fin ? 8'h00 : ch_s1;
			pos_q     <= fin ? '0 : pos_q + POS_W'(1);
			start_q   <= start_d;
			closing_q <= closing_d;
			sbp_q     <= sbp_d;
			tags_q    <= tags_d;
			level_q   <= level_d;
		end
	end

	// ---------------------------------------------------------------
	// Level table: row of level-1 is fetched into the registered read ahead
	// ---------------------------------------------------------------
	logic signed [LVL_W-1:0] level_nx;   // level in effect next cycle
	assign level_nx = proc ? level_d : level_q;

	// {en, idx, data}
	assign tbl_wr  = {proc && emit, lvl_to_idx(level_q), tags_q[IDX_W-1:0]};
	assign par_idx = lvl_to_idx(level_q - LVL_W'(1));

	mts_level_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.clr     (proc && fin),
		.rd_idx  (lvl_to_idx(level_nx - LVL_W'(1))),
		.rd_data (tbl_rd_data),
		.vld_idx (par_idx),
		.vld     (tbl_vld)
	);

	// no parent row below the lowest level
	assign par_ok = (level_q != LVL_MIN) && tbl_vld;

	// ---------------------------------------------------------------
	// Result assembly
	// ---------------------------------------------------------------
	always_comb begin
		tag_res               = '0;
		tag_res.tag_index     = tags_q[IDX_W-1:0];
		tag_res.tag_pos       = start_q;
		tag_res.tag_len       = pos_q - start_q + POS_W'(1);
		tag_res.level         = level_q;
		tag_res.parent        = par_ok ? tbl_rd_data : '0;
		tag_res.parent_found  = par_ok;
		tag_res.level_clipped = clip;
		tag_res.last_result   = !fin;

		done_res              = '0;
		done_res.done_res     = 1'b1;
		done_res.tag_count    = emit ? tags_q + CNT_W'(1) : tags_q;
		done_res.last_result  = 1'b1;
	end

	assign res0   = emit ? tag_res : done_res;
	assign push_n = proc ? (2'(emit) + 2'(fin)) : 2'd0;

	result_t out_res;

	mts_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (res0),
		.d1        (done_res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {3'b000, out_res.tag_count, out_res.level_clipped,
	                       out_res.parent_found, out_res.parent, out_res.level,
	                       out_res.tag_len, out_res.tag_pos, out_res.tag_index};
	assign m_axis_tuser = out_res.done_res;
	assign m_axis_tlast = out_res.last_result;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// the end-of-text word is always the last one of its byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("end-of-text word without tlast");

	// the final byte of a text leaves the scanner in its reset state
	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		proc && fin |=> (tags_q == '0 && level_q == '0 && !inside_q && cd_q == '0))
		else $error("scan state not cleared after end of text");

	// tag count never passes the limit
	a_tag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tags_q <= CNT_W'(MAX_TAGS))
		else $error("tag count above limit");

	// input stalls only while a byte is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1)
		else $error("input stalled with empty stage");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for markup_tag_scanner_with_nesting_top: byte stream in, tag words out.
// Predicts every result word in a scoreboard class and checks tdata/tuser/tlast per word.
// Depends on mts_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module testbench;
	import mts_pkg::*;

	localparam int LVL_LO = -(LEVEL_RANGE / 2);
	localparam int LVL_HI = LEVEL_RANGE / 2 - 1;

	// ------------------------------------------------------------------
	// Scoreboard: shadow copy of the scanner state plus the words still due
	// ------------------------------------------------------------------
	class tag_scoreboard;
		bit        in_tag;
		bit [7:0]  comment_lvl;
		bit [7:0]  prev_ch;
		bit [15:0] cur_pos;
		bit [15:0] open_pos;
		bit        is_closing;
		bit        want_second;
		int        n_tags;
		int        level_now;
		bit [11:0] last_tag_at [LEVEL_RANGE];
		bit        last_tag_ok [LEVEL_RANGE];

		result_t   words_due[$];
		int        errors;
		int        words_seen;
		int        tags_seen;
		int        texts_seen;
		int        clipped_seen;
		int        parented_seen;

		function new();
			errors = 0;
			words_seen = 0;
			tags_seen = 0;
			texts_seen = 0;
			clipped_seen = 0;
			parented_seen = 0;
			clear_text();
		endfunction

		function void clear_text();
			in_tag = 1'b0;
			comment_lvl = '0;
			prev_ch = '0;
			cur_pos = '0;
			open_pos = '0;
			is_closing = 1'b0;
			want_second = 1'b0;
			n_tags = 0;
			level_now = 0;
			foreach (last_tag_ok[i]) begin
				last_tag_ok[i] = 1'b0;
				last_tag_at[i] = '0;
			end
		endfunction

		function int pending();
			return words_due.size();
		endfunction

		// Advance the shadow scanner by one accepted byte; queue its words.
		function void note_byte(bit [7:0] c, bit fin);
			result_t tag_w;
			result_t end_w;
			bit      got_tag;
			int      nxt;
			got_tag = 1'b0;
			tag_w = '0;
			end_w = '0;

			if (want_second) begin
				is_closing = (c == CH_SLASH);
				want_second = 1'b0;
			end

			if (c == CH_LT) begin
				// '<' inside a comment is plain text; inside a tag it restarts the tag
				if (comment_lvl == 0) begin
					open_pos = cur_pos;
					in_tag = 1'b1;
					want_second = 1'b1;
					is_closing = 1'b0;
				end
			end else if (c == CH_BANG) begin
				if (in_tag && prev_ch == CH_LT && comment_lvl != 8'hFF)
					comment_lvl++;
			end else if (c == CH_GT) begin
				if (comment_lvl != 0) begin
					if (prev_ch == CH_DASH)
						comment_lvl--;
					if (comment_lvl == 0)
						in_tag = 1'b0;	// tag swallowed by its comment
				end else if (in_tag) begin
					in_tag = 1'b0;
					if (n_tags < MAX_TAGS) begin
						got_tag = 1'b1;
						tag_w.tag_index = 12'(n_tags);
						tag_w.tag_pos = open_pos;
						tag_w.tag_len = cur_pos - open_pos + 16'd1;
						tag_w.level = 6'(level_now);
						if (level_now - 1 >= LVL_LO && last_tag_ok[level_now - 1 - LVL_LO]) begin
							tag_w.parent_found = 1'b1;
							tag_w.parent = last_tag_at[level_now - 1 - LVL_LO];
						end
						last_tag_at[level_now - LVL_LO] = 12'(n_tags);
						last_tag_ok[level_now - LVL_LO] = 1'b1;
						nxt = level_now + 1;
						if (is_closing)
							nxt -= 2;
						if (prev_ch == CH_SLASH || prev_ch == CH_DASH)
							nxt -= 1;
						if (nxt > LVL_HI) begin
							nxt = LVL_HI;
							tag_w.level_clipped = 1'b1;
						end
						if (nxt < LVL_LO) begin
							nxt = LVL_LO;
							tag_w.level_clipped = 1'b1;
						end
						level_now = nxt;
						n_tags++;
					end
				end
			end

			prev_ch = c;
			cur_pos++;

			if (got_tag) begin
				tag_w.last_result = !fin;
				words_due.push_back(tag_w);
			end
			if (fin) begin
				end_w.done_res = 1'b1;
				end_w.tag_count = 13'(n_tags);
				end_w.last_result = 1'b1;
				words_due.push_back(end_w);
				clear_text();
			end
		endfunction

		task report(string msg);
			$display("mismatch at word %0d: %s", words_seen, msg);
			errors++;
		endtask

		task check_field(string nm, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", nm, got, want));
		endtask

		task check_word(logic [79:0] data, logic done, logic lst);
			result_t w;
			if (words_due.size() == 0) begin
				report($sformatf("unexpected word %h user %b last %b", data, done, lst));
			end else begin
				w = words_due.pop_front();
				check_field("tag_index", 16'(data[11:0]), 16'(w.tag_index));
				check_field("tag_pos", data[27:12], w.tag_pos);
				check_field("tag_len", data[43:28], w.tag_len);
				check_field("level", 16'(data[49:44]), 16'($unsigned(w.level)));
				check_field("parent", 16'(data[61:50]), 16'(w.parent));
				check_field("parent_found", 16'(data[62]), 16'(w.parent_found));
				check_field("level_clipped", 16'(data[63]), 16'(w.level_clipped));
				check_field("tag_count", 16'(data[76:64]), 16'(w.tag_count));
				check_field("pad", 16'(data[79:77]), 16'd0);
				check_field("done_res", 16'(done), 16'(w.done_res));
				check_field("last_result", 16'(lst), 16'(w.last_result));
				if (w.done_res)
					texts_seen++;
				else
					tags_seen++;
				if (w.level_clipped)
					clipped_seen++;
				if (w.parent_found)
					parented_seen++;
			end
			words_seen++;
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;		// [7:0] ch
	logic        s_axis_tlast = 1'b0;	// last byte of the text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;		// [11:0] tag_index .. [76:64] tag_count, rest 0
	logic        m_axis_tuser;		// done_res
	logic        m_axis_tlast;		// last_result

	markup_tag_scanner_with_nesting_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	tag_scoreboard sb = new();

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Safety net: the slowest legal run is well under a tenth of this.
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Idle pattern: mostly short gaps, a few long ones, and calm stretches
	// with no gaps at all.
	// ------------------------------------------------------------------
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_hold = 0;
	int bytes_sent = 0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int tx_gap();
		if ($urandom_range(0, 299) == 0)
			tx_calm = !tx_calm;
		if (tx_calm || $urandom_range(0, 3) != 0)
			return 0;
		return gap_len();
	endfunction

	// Receiver back-pressure, driven at the rising edge
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			rx_calm <= !rx_calm;
		if (rx_hold != 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= gap_len() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result monitor: values read here are the ones present at the edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// ------------------------------------------------------------------
	// Text building and driving
	// ------------------------------------------------------------------
	bit [7:0] text_q[$];

	function automatic bit is_delim(bit [7:0] c);
		return c == CH_LT || c == CH_GT || c == CH_BANG || c == CH_DASH || c == CH_SLASH;
	endfunction

	// any byte that the scanner treats as plain text
	function automatic bit [7:0] plain_ch();
		bit [7:0] c;
		do
			c = 8'($urandom);
		while (is_delim(c));
		return c;
	endfunction

	function automatic bit [7:0] delim_ch();
		case ($urandom_range(0, 4))
			0: return CH_LT;
			1: return CH_GT;
			2: return CH_BANG;
			3: return CH_DASH;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic void add_plain(int n);
		repeat (n) text_q.push_back(plain_ch());
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// One random piece of markup: mostly well-formed, some noise and breakage
	function automatic void add_fragment();
		int k;
		int nest;
		k = $urandom_range(0, 99);
		if (k < 28) begin
			// opening tag, maybe with an attribute-like tail
			text_q.push_back(CH_LT);
			add_plain($urandom_range(1, 6));
			if ($urandom_range(0, 2) == 0) begin
				text_q.push_back(" ");
				add_plain($urandom_range(1, 8));
			end
			text_q.push_back(CH_GT);
		end else if (k < 45) begin
			text_q.push_back(CH_LT);
			text_q.push_back(CH_SLASH);
			add_plain($urandom_range(1, 6));
			text_q.push_back(CH_GT);
		end else if (k < 55) begin
			// self-closing; sometimes a dash as the byte before '>'
			text_q.push_back(CH_LT);
			add_plain($urandom_range(1, 5));
			text_q.push_back($urandom_range(0, 3) == 0 ? CH_DASH : CH_SLASH);
			text_q.push_back(CH_GT);
		end else if (k < 65) begin
			// comment, sometimes nested a few deep
			nest = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
			repeat (nest) begin
				text_q.push_back(CH_LT);
				text_q.push_back(CH_BANG);
			end
			text_q.push_back(CH_DASH);
			add_plain($urandom_range(0, 8));
			if ($urandom_range(0, 1) == 0) begin
				// brackets inside a comment are ignored
				text_q.push_back(CH_LT);
				add_plain($urandom_range(0, 3));
			end
			repeat (nest) begin
				text_q.push_back(CH_DASH);
				text_q.push_back(CH_GT);
			end
		end else if (k < 80) begin
			add_plain($urandom_range(1, 12));
		end else if (k < 92) begin
			repeat ($urandom_range(1, 8))
				text_q.push_back($urandom_range(0, 1) ? delim_ch() : 8'($urandom));
		end else begin
			// broken pieces: unterminated tag, stray '>', half-open comment
			case ($urandom_range(0, 2))
				0: begin
					text_q.push_back(CH_LT);
					add_plain($urandom_range(0, 4));
				end
				1: text_q.push_back(CH_GT);
				default: begin
					text_q.push_back(CH_LT);
					text_q.push_back(CH_BANG);
					add_plain($urandom_range(0, 4));
				end
			endcase
		end
	endfunction

	// One word into the slave side; noted once the handshake completes
	task automatic send_byte(input bit [7:0] c, input bit fin);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			s_axis_tlast <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(c, fin);
		bytes_sent++;
	endtask

	// Send the built text; tlast rides on its final byte
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// Hold off the sender until every predicted word has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		bit drained;
		drained = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: byte extremes, nesting, closing and self-closing tags,
		// a comment that swallows its tag, a restarted tag, a stray '>'.
		text_q.push_back(8'h00);
		add_str("<a><b/></b>>");
		text_q.push_back(CH_LT);
		text_q.push_back(CH_BANG);
		add_str("-->");
		add_str("<<c->");
		text_q.push_back(8'hFF);
		send_text();
		// last byte closes a tag: tag word and count word from one byte
		add_str("<d>");
		send_text();
		// one-byte text, count of zero
		add_str("x");
		send_text();

		// Level climbs past the top and clamps
		repeat (34) add_str("<a>");
		add_str(".");
		send_text();

		// Closing tags drive the level to the floor: no parent level there
		repeat (20) add_str("</>");
		send_text();

		// Random texts of mostly well-formed markup
		while (bytes_sent < 1350) begin
			repeat ($urandom_range(3, 20)) add_fragment();
			send_text();
			if (!drained && bytes_sent > 675) begin
				drain();
				drained = 1'b1;
			end
		end

		// Wind down: everything predicted must arrive, then nothing more
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d bytes in %0d texts: %0d tag words, %0d with parent, %0d clipped",
			bytes_sent, sb.texts_seen, sb.tags_seen, sb.parented_seen, sb.clipped_seen);
		$display("%0d words checked, %0d mismatches", sb.words_seen, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
src/mts_pkg.sv
src/mts_level_table.sv
src/mts_result_fifo.sv
src/markup_tag_scanner_with_nesting_top.sv
verif/testbench.sv
